>>> rtl/core/ucfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfd_pkg: shared types and constants of the command frame decoder
// frame layout codes, status codes, register indexes and the frame record
// ----------------------------------------------------------------------------
package ucfd_pkg;

    localparam logic [7:0] START_BYTE = 8'hFE;

    // frame result status
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_XOR = 2'd1;
    localparam logic [1:0] ST_LEN = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_LEN     = 2'd0;
    localparam logic [1:0] CFG_STATE_FUNC  = 2'd1;
    localparam logic [1:0] CFG_MANUAL_FUNC = 2'd2;

    // reset values of the configuration registers
    localparam logic [15:0] MAX_LEN_RESET     = 16'd128;
    localparam logic [15:0] STATE_FUNC_RESET  = 16'h0051;
    localparam logic [15:0] MANUAL_FUNC_RESET = 16'h0052;

    // default depth of the frame queue
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // one finished frame, handed from the parser to the executor
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] func;
        logic [15:0] len;
        logic [7:0]  first;
    } frame_evt_t;

endpackage
`default_nettype wire

>>> rtl/core/ucfd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfd_parser: byte-level frame parser
// tracks the frame phase, accumulates the xor and emits one record per frame
// ----------------------------------------------------------------------------
module ucfd_parser (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    input  wire logic [7:0]           byte_data,
    input  wire logic [15:0]          max_len,
    output      logic                 evt_valid,
    output      ucfd_pkg::frame_evt_t evt
);
    import ucfd_pkg::*;

    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_FMSB  = 3'd1;
    localparam logic [2:0] PH_FLSB  = 3'd2;
    localparam logic [2:0] PH_LMSB  = 3'd3;
    localparam logic [2:0] PH_LLSB  = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CHECK = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] func_reg, func_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  first_reg, first_next;
    logic [15:0] len_full;
    logic [15:0] count_inc;

    assign len_full  = {len_reg[15:8], byte_data};
    assign count_inc = count_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        func_next  = func_reg;
        len_next   = len_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        first_next = first_reg;
        evt_valid  = 1'b0;
        evt.status = ST_OK;
        evt.func   = func_reg;
        evt.len    = len_reg;
        evt.first  = first_reg;
        if (byte_valid)
        begin
            case (phase_reg)
                PH_FMSB:
                begin
                    func_next  = {byte_data, 8'h00};
                    xor_next   = xor_reg ^ byte_data;
                    phase_next = PH_FLSB;
                end
                PH_FLSB:
                begin
                    func_next  = {func_reg[15:8], byte_data};
                    xor_next   = xor_reg ^ byte_data;
                    phase_next = PH_LMSB;
                end
                PH_LMSB:
                begin
                    len_next   = {byte_data, 8'h00};
                    xor_next   = xor_reg ^ byte_data;
                    phase_next = PH_LLSB;
                end
                PH_LLSB:
                begin
                    len_next   = len_full;
                    xor_next   = xor_reg ^ byte_data;
                    count_next = 16'd0;
                    first_next = 8'd0;
                    if (len_full > max_len)
                    begin
                        // over the limit: report now and resynchronize
                        phase_next = PH_WAIT;
                        evt_valid  = 1'b1;
                        evt.status = ST_LEN;
                        evt.len    = len_full;
                        evt.first  = 8'd0;
                    end
                    else if (len_full == 16'd0)
                    begin
                        phase_next = PH_CHECK;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (count_reg == 16'd0)
                    begin
                        first_next = byte_data;
                    end
                    xor_next   = xor_reg ^ byte_data;
                    count_next = count_inc;
                    if (count_inc >= len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_WAIT;
                    evt_valid  = 1'b1;
                    evt.status = (xor_reg == byte_data) ? ST_OK : ST_XOR;
                    evt.first  = (len_reg == 16'd0) ? 8'd0 : first_reg;
                end
                default:
                begin
                    phase_next = PH_WAIT;
                    if (byte_data == START_BYTE)
                    begin
                        xor_next   = START_BYTE;
                        phase_next = PH_FMSB;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            func_reg  <= 16'd0;
            len_reg   <= 16'd0;
            count_reg <= 16'd0;
            xor_reg   <= 8'd0;
            first_reg <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            func_reg  <= func_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
            first_reg <= first_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/ucfd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfd_queue: small frame record queue
// decouples the parser from the executor so each side stalls on its own
// ----------------------------------------------------------------------------
module ucfd_queue #(
    parameter int DEPTH = ucfd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire ucfd_pkg::frame_evt_t push_data,
    output      logic                 not_full,
    input  wire logic                 pop,
    output      logic                 not_empty,
    output      ucfd_pkg::frame_evt_t pop_data
);
    import ucfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    frame_evt_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    assign not_full  = (count_reg != FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/ucfd_exec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucfd_exec: frame executor
// applies good frames to the control registers and holds the result item
// ----------------------------------------------------------------------------
module ucfd_exec (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 evt_valid,
    input  wire ucfd_pkg::frame_evt_t evt,
    output      logic                 evt_pop,
    input  wire logic [15:0]          state_func,
    input  wire logic [15:0]          manual_func,
    output      logic                 res_valid,
    input  wire logic                 res_ready,
    output      logic [63:0]          res_data,
    output      logic [7:0]           robot_state
);
    import ucfd_pkg::*;

    logic        valid_reg, valid_next;
    frame_evt_t  evt_reg;
    logic [7:0]  robot_reg, robot_next;
    logic [7:0]  auto_reg, auto_next;
    logic        apply;

    assign evt_pop = evt_valid && (!valid_reg || res_ready);
    assign apply   = (evt.status == ST_OK) && (evt.len != 16'd0);

    always_comb
    begin
        robot_next = robot_reg;
        auto_next  = auto_reg;
        valid_next = valid_reg;
        if (res_ready)
        begin
            valid_next = 1'b0;
        end
        if (evt_pop)
        begin
            valid_next = 1'b1;
            // state code wins when both codes match
            if (apply && (evt.func == state_func))
            begin
                robot_next = evt.first;
            end
            else if (apply && (evt.func == manual_func))
            begin
                auto_next = evt.first;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_pop)
        begin
            evt_reg <= evt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            robot_reg <= 8'd0;
            auto_reg  <= 8'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            robot_reg <= robot_next;
            auto_reg  <= auto_next;
        end
    end

    assign res_valid   = valid_reg;
    assign robot_state = robot_reg;
    assign res_data    = {6'd0, auto_reg, robot_reg, evt_reg.first,
                          evt_reg.len, evt_reg.func, evt_reg.status};

endmodule
`default_nettype wire

>>> rtl/core/uart_command_frame_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_command_frame_decoder_top: command frame decoder for a byte link
// parses 0xFE-framed commands with xor checksum and drives control registers
// ----------------------------------------------------------------------------
// The decoder takes one received byte per cycle on the slave stream,
// while the record queue has room, and returns one result item per
// finished frame on the master stream: when the checksum byte arrives
// (status good or checksum mismatch), or right at the length low byte
// when the length is over max_payload_length (status length error,
// parser resynchronizes). Bytes outside a frame other than 0xFE are
// dropped. The record is queued at the edge that takes the frame's last
// byte and moved into the output register, which raises m_tvalid, once
// that register is empty or being read. The parser and the register
// executor are separated by a record queue of QUEUE_DEPTH entries plus
// the output register, so the slave side keeps taking bytes while
// results wait; it stops only once the queue is full. A good frame with
// a non-empty payload loads the robot state register (function equal to
// state_function_code) or else the auto-control register (function
// equal to manual_function_code) with its first payload byte.
// Configuration writes are meant for idle periods.
// ----------------------------------------------------------------------------
module uart_command_frame_decoder_top #(
    parameter int QUEUE_DEPTH = ucfd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte input stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // [1:0] frame_status, [17:2] function_code, [33:18] payload_length,
    // [41:34] first_payload_byte, [49:42] robot_state_value,
    // [57:50] auto_control_value, [63:58] zero
    output      logic [63:0] m_tdata,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import ucfd_pkg::*;

    logic        byte_take;
    logic        parse_valid;
    frame_evt_t  parse_evt;
    logic        q_ready;
    logic        q_valid;
    frame_evt_t  q_evt;
    logic        q_pop;
    logic [7:0]  robot_state;

    logic [15:0] max_len_reg;
    logic [15:0] state_func_reg;
    logic [15:0] manual_func_reg;

    // configuration registers, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg     <= MAX_LEN_RESET;
            state_func_reg  <= STATE_FUNC_RESET;
            manual_func_reg <= MANUAL_FUNC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_LEN:     max_len_reg     <= cfg_wdata;
                CFG_STATE_FUNC:  state_func_reg  <= cfg_wdata;
                CFG_MANUAL_FUNC: manual_func_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // a byte is taken only while the queue has room for a possible record
    assign s_tready  = q_ready;
    assign byte_take = s_tvalid && s_tready;

    // front: parser
    ucfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_take),
        .byte_data  (s_tdata),
        .max_len    (max_len_reg),
        .evt_valid  (parse_valid),
        .evt        (parse_evt)
    );

    // record queue between front and back
    ucfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (parse_valid),
        .push_data (parse_evt),
        .not_full  (q_ready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_evt)
    );

    // back: register update and result output
    ucfd_exec u_exec (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt_valid   (q_valid),
        .evt         (q_evt),
        .evt_pop     (q_pop),
        .state_func  (state_func_reg),
        .manual_func (manual_func_reg),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_data    (m_tdata),
        .robot_state (robot_state)
    );

`ifndef NO_ASSERTIONS
    // a record never arrives at a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        parse_valid |-> q_ready)
        else $error("frame record pushed into full queue");

    // robot state only moves when a record is taken by the executor
    a_state_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(robot_state) |-> $past(q_pop))
        else $error("robot state changed without a frame");

    // the status code of a result is never the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("invalid frame status");
`endif

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the command frame decoder
// streams 0xFE-framed commands, junk and broken frames into the byte input,
// predicts every result item from a behavioral copy of the parser and the
// control registers, and compares the result stream field by field
// ----------------------------------------------------------------------------
module tb;
    import ucfd_pkg::*;

    localparam int          ITEM_TARGET  = 550;  // frame bytes in the random part
    localparam int          NUM_SETTINGS = 6;    // register settings walked through
    localparam int          IDLE_PCT     = 26;   // idle chance per cycle, both sides
    localparam int          DRAIN_CYCLES = 8;    // parser finishes well within this
    localparam int          HOLD_CYCLES  = 150;  // long receiver hold-off
    localparam int          STALL_LIMIT  = 2000; // cycles without any handshake
    localparam int          MAX_REPORTS  = 10;
    localparam logic [1:0]  CFG_UNUSED   = 2'd3; // index with no register behind it

    // parser position inside a frame
    typedef enum logic [2:0] {
        WAIT_SOF,
        FUNC_HI,
        FUNC_LO,
        LEN_HI,
        LEN_LO,
        PAYLOAD,
        CHECKSUM
    } parse_phase_e;

    // one result item, laid out as on m_tdata
    typedef struct packed {
        logic [5:0]  pad;
        logic [7:0]  auto_ctrl;
        logic [7:0]  robot_state;
        logic [7:0]  first_byte;
        logic [15:0] length;
        logic [15:0] func;
        logic [1:0]  status;
    } frame_result_t;

    // ------------------------------------------------------------------------
    // frame scoreboard: parser copy, register copy and pending results
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [15:0]   max_len     = MAX_LEN_RESET;
        logic [15:0]   state_func  = STATE_FUNC_RESET;
        logic [15:0]   manual_func = MANUAL_FUNC_RESET;

        parse_phase_e  phase       = WAIT_SOF;
        logic [15:0]   cur_func    = '0;
        logic [15:0]   cur_len     = '0;
        logic [15:0]   payload_cnt = '0;
        logic [7:0]    xor_acc     = '0;
        logic [7:0]    first_held  = '0;
        logic [7:0]    robot_reg   = '0;
        logic [7:0]    auto_reg    = '0;

        frame_result_t expected_frames[$];
        int            bytes_seen;
        int            failures;
        int            n_good;
        int            n_xor;
        int            n_len;

        function void write_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_MAX_LEN:     max_len     = value;
                CFG_STATE_FUNC:  state_func  = value;
                CFG_MANUAL_FUNC: manual_func = value;
                default: ;  // no register, write dropped
            endcase
        endfunction

        function void push_result(logic [1:0] status, logic [7:0] first);
            frame_result_t r;
            r = '0;
            r.status      = status;
            r.func        = cur_func;
            r.length      = cur_len;
            r.first_byte  = first;
            r.robot_state = robot_reg;
            r.auto_ctrl   = auto_reg;
            expected_frames.push_back(r);
        endfunction

        // advance the parser copy by one accepted byte
        function void note_byte(logic [7:0] c);
            logic good;
            bytes_seen++;
            case (phase)
                FUNC_HI:
                begin
                    cur_func = {c, 8'h00};
                    xor_acc ^= c;
                    phase = FUNC_LO;
                end
                FUNC_LO:
                begin
                    cur_func[7:0] = c;
                    xor_acc ^= c;
                    phase = LEN_HI;
                end
                LEN_HI:
                begin
                    cur_len = {c, 8'h00};
                    xor_acc ^= c;
                    phase = LEN_LO;
                end
                LEN_LO:
                begin
                    cur_len[7:0] = c;
                    xor_acc ^= c;
                    payload_cnt = '0;
                    first_held = '0;
                    if (cur_len > max_len)
                    begin
                        // over the limit: reported right away, back to hunting
                        phase = WAIT_SOF;
                        push_result(ST_LEN, 8'h00);
                    end
                    else
                        phase = (cur_len == 0) ? CHECKSUM : PAYLOAD;
                end
                PAYLOAD:
                begin
                    if (payload_cnt == 0)
                        first_held = c;
                    xor_acc ^= c;
                    payload_cnt++;
                    if (payload_cnt >= cur_len)
                        phase = CHECKSUM;
                end
                CHECKSUM:
                begin
                    good = (xor_acc == c);
                    if (good && cur_len != 0)
                    begin
                        // state code wins when both codes match
                        if (cur_func == state_func)
                            robot_reg = first_held;
                        else if (cur_func == manual_func)
                            auto_reg = first_held;
                    end
                    phase = WAIT_SOF;
                    push_result(good ? ST_OK : ST_XOR, (cur_len == 0) ? 8'h00 : first_held);
                end
                default:
                begin
                    phase = WAIT_SOF;
                    if (c == START_BYTE)
                    begin
                        xor_acc = START_BYTE;
                        phase = FUNC_HI;
                    end
                end
            endcase
        endfunction

        function void flag(string why, frame_result_t want, frame_result_t got);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t %s: expected st=%0d fn=%h len=%h first=%h robot=%h auto=%h",
                         $time, why, want.status, want.func, want.length,
                         want.first_byte, want.robot_state, want.auto_ctrl,
                         "\n    got      st=%0d fn=%h len=%h first=%h robot=%h auto=%h",
                         got.status, got.func, got.length,
                         got.first_byte, got.robot_state, got.auto_ctrl);
        endfunction

        function void check_result(logic [63:0] raw);
            frame_result_t got;
            frame_result_t want;
            got = raw;
            if (expected_frames.size() == 0)
                flag("result with no frame pending", '0, got);
            else
            begin
                want = expected_frames.pop_front();
                case (want.status)
                    ST_OK:   n_good++;
                    ST_XOR:  n_xor++;
                    default: n_len++;
                endcase
                if (got.status != want.status || got.func != want.func ||
                    got.length != want.length || got.first_byte != want.first_byte ||
                    got.robot_state != want.robot_state || got.auto_ctrl != want.auto_ctrl)
                    flag("result mismatch", want, got);
            end
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function void flush_leftover();
            while (expected_frames.size() != 0)
                flag("frame never reported", expected_frames.pop_front(), '0);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, dut and shared stimulus state
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    frame_scoreboard sb = new;

    logic [7:0]  frame_q[$];       // bytes waiting to be streamed
    int          frame_head;       // where the frame under construction starts
    int          frame_bytes;      // bytes of well-formed or broken frames sent
    int          settings_applied;
    int          holds_requested;
    int          holds_done;
    bit          tx_idle_en;
    bit          rx_idle_en;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    uart_command_frame_decoder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // monitor: results are checked before the byte of the same edge is noted,
    // since a byte's own result can only show up on a later edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (s_tvalid && s_tready)
            sb.note_byte(s_tdata);
    end

    // watchdog: ends the run when the stream stops moving
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t no handshake for %0d cycles", $time, quiet);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_requested)
            begin
                // sender keeps going, so the frame queue fills and s_tready drops
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            m_tready <= !rx_idle_en || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------
    // offer one byte and return at the edge that takes it; valid stays high
    // so back-to-back bytes need no second assignment in the same step
    task automatic send_byte(input logic [7:0] b);
        if (tx_idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            // idle gap of geometric length, same per-cycle rate as the receiver
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (tx_idle_en && $urandom_range(99) < IDLE_PCT);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_span(input int lo, input int hi);
        for (int i = lo; i < hi; i++)
            send_byte(frame_q[i]);
    endtask

    // stop offering and let every pending result come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [15:0] limit, input logic [15:0] st_code,
                                input logic [15:0] man_code, input bit poke_unused);
        logic [1:0]  idx [4];
        logic [15:0] val [4];
        int          n;
        idx[0] = CFG_MAX_LEN;     val[0] = limit;
        idx[1] = CFG_STATE_FUNC;  val[1] = st_code;
        idx[2] = CFG_MANUAL_FUNC; val[2] = man_code;
        idx[3] = CFG_UNUSED;      val[3] = 16'($urandom);
        n = poke_unused ? 4 : 3;
        for (int i = 0; i < n; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // ------------------------------------------------------------------------
    // frame builders
    // ------------------------------------------------------------------------
    function automatic void push_header(input logic [15:0] func, input logic [15:0] len);
        frame_head = frame_q.size();
        frame_q.push_back(START_BYTE);
        frame_q.push_back(func[15:8]);
        frame_q.push_back(func[7:0]);
        frame_q.push_back(len[15:8]);
        frame_q.push_back(len[7:0]);
    endfunction

    // xor of the current frame, optionally corrupted
    function automatic void append_checksum(input bit bad);
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = frame_head; i < frame_q.size(); i++)
            sum ^= frame_q[i];
        if (bad)
            sum ^= 8'($urandom_range(1, 255));
        frame_q.push_back(sum);
    endfunction

    function automatic void build_frame(input logic [15:0] func, input logic [15:0] len,
                                        input bit bad, input bit header_only);
        frame_q.delete();
        push_header(func, len);
        if (!header_only)
        begin
            // start bytes inside the payload are plain data
            for (int i = 0; i < len; i++)
                frame_q.push_back(($urandom_range(9) == 0) ? START_BYTE : 8'($urandom));
            append_checksum(bad);
        end
    endfunction

    // one random unit: junk, a well-formed frame, an oversize header, or a
    // frame cut short so that the parser eats into whatever comes next
    task automatic random_frame();
        int          pick;
        int          cut;
        logic [15:0] func;
        logic [15:0] len;
        bit          bad;
        bit          header_only;
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            frame_q.delete();
            repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
            send_span(0, frame_q.size());
        end
        else
        begin
            case ($urandom_range(3))
                0:       func = sb.state_func;
                1:       func = sb.manual_func;
                2:       func = 16'($urandom);
                default: func = sb.state_func ^ (16'h0001 << $urandom_range(15));
            endcase
            pick = $urandom_range(99);
            if (pick < 10)
                len = 16'h0000;
            else if (pick < 82 || sb.max_len == 16'hFFFF)
                len = 16'($urandom_range(1, 6));
            else if (pick < 90)
                len = 16'($urandom_range(7, 24));
            else
            begin
                case ($urandom_range(2))
                    0:       len = 16'hFFFF;
                    1:       len = sb.max_len + 16'd1;
                    default: len = 16'($urandom_range(sb.max_len + 1, 16'hFFFF));
                endcase
            end
            header_only = (len > sb.max_len);
            bad = ($urandom_range(99) < 15);
            build_frame(func, len, bad, header_only);
            cut = frame_q.size();
            if (!header_only && $urandom_range(99) < 5)
                cut = $urandom_range(1, cut - 1);
            send_span(0, cut);
            frame_bytes += cut;
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int          budget;
        int          cut;
        logic [15:0] limit;
        logic [15:0] st_code;
        logic [15:0] man_code;
        bit          poke;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        cfg_we     = 1'b0;
        cfg_index  = CFG_MAX_LEN;
        cfg_wdata  = 16'h0000;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on reset settings
        frame_q.delete();
        frame_q.push_back(8'h00);                  // junk while hunting
        frame_q.push_back(8'hFF);
        push_header(STATE_FUNC_RESET, 16'hFFFF);   // length over limit, all ones
        push_header(STATE_FUNC_RESET, 16'h0000);   // empty payload, good, no update
        append_checksum(1'b0);
        push_header(STATE_FUNC_RESET, 16'h0001);   // start byte as payload
        frame_q.push_back(START_BYTE);
        append_checksum(1'b0);
        push_header(MANUAL_FUNC_RESET, 16'h0002);  // bad checksum, no update
        frame_q.push_back(8'hAB);
        frame_q.push_back(8'h55);
        append_checksum(1'b1);
        push_header(MANUAL_FUNC_RESET, 16'h0001);  // loads auto-control
        frame_q.push_back(8'h7F);
        append_checksum(1'b0);
        send_span(0, frame_q.size());

        // random part, one register setting per phase
        budget = 0;
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            poke = 1'b0;
            case (p)
                0:
                begin
                    limit = MAX_LEN_RESET; st_code = STATE_FUNC_RESET;
                    man_code = MANUAL_FUNC_RESET; poke = 1'b1;
                end
                1:
                begin
                    limit = 16'h0000; st_code = 16'hFFFF; man_code = 16'h0000;
                end
                2:
                begin
                    // both codes equal: state register takes it
                    limit = 16'hFFFF; st_code = 16'h1234; man_code = 16'h1234;
                end
                3:
                begin
                    limit = 16'd4; st_code = 16'($urandom); man_code = 16'($urandom);
                end
                4:
                begin
                    limit = 16'($urandom_range(1, 20)); st_code = 16'($urandom);
                    man_code = 16'($urandom); poke = 1'b1;
                end
                default:
                begin
                    limit = 16'd6; st_code = 16'h8001; man_code = 16'hFE00;
                end
            endcase

            // phase 1 runs with no idling on either side
            tx_idle_en = (p != 1);
            rx_idle_en = (p != 1);
            wait_idle();
            if (p % 2 == 1)
            begin
                // registers change while a frame sits half parsed
                build_frame(st_code, 16'($urandom_range(1, 6)), 1'b0, 1'b0);
                cut = $urandom_range(1, frame_q.size() - 1);
                send_span(0, cut);
                wait_idle();
                write_config(limit, st_code, man_code, poke);
                send_span(cut, frame_q.size());
                frame_bytes += frame_q.size();
            end
            else
                write_config(limit, st_code, man_code, poke);

            if (p == 2)
            begin
                // one long payload, low length byte zero
                build_frame(st_code, 16'd256, 1'b0, 1'b0);
                send_span(0, frame_q.size());
                frame_bytes += frame_q.size();
            end
            if (p == 3)
            begin
                // dense offers against a stalled receiver
                tx_idle_en = 1'b0;
                holds_requested++;
            end

            budget += ITEM_TARGET / NUM_SETTINGS;
            while (frame_bytes < budget)
                random_frame();
        end

        wait_idle();
        sb.flush_leftover();

        $display("run: %0d bytes over %0d register settings, one long receiver hold-off",
                 sb.bytes_seen, settings_applied);
        $display("frames: %0d good, %0d checksum errors, %0d length errors, %0d failures",
                 sb.n_good, sb.n_xor, sb.n_len, sb.failures);
        if (sb.failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/ucfd_pkg.sv
rtl/core/ucfd_parser.sv
rtl/core/ucfd_queue.sv
rtl/core/ucfd_exec.sv
rtl/core/uart_command_frame_decoder_top.sv
verif/tb.sv
